// ===== rtl/gase_pkg.sv =====
package gase_pkg;

    localparam int NUM_SLOTS_DEF   = 64;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_WORKERS_DEF = 16;

    localparam logic signed [15:0] EXP_FLOOR = -16'sd126;
    localparam logic [31:0]        NEXT_INIT = 32'hFFFF_FFFF;
    localparam int                 CFG_W     = 15;

    typedef enum logic [1:0] {
        REG_WORKER_COUNT = 2'd0,
        REG_UPDATE_COUNT = 2'd1,
        REG_SLOT_BASE    = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_LEARN,
        ST_REC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]        src_ip;
        logic [14:0]        slot_number;
        logic [31:0]        tsi;
        logic [31:0]        worker_next;
        logic signed [15:0] worker_exp;
        logic signed [31:0] entry_value;
        logic               entry_last;
    } beat_t;

endpackage

// ===== rtl/gradient_aggregation_slot_engine_core.sv =====
// Gradient aggregation slot engine.
// Input: start/busy command port; a beat is taken when start is high and
// busy is low. Every beat carries one packet entry plus the packet header.
// A front queue of two beats takes beats while the back end works.
// Back end: an entry takes an accumulator read, then an add and write.
// A last entry then walks the learned address table; for a slot in range
// it scans the slot's worker records and, if all their next values equal
// the tsi or the tsi is below the least of them, scans them again for the
// exponent and emits update_count results, each read and then cleared.
// Results appear on the out_* ports for one cycle, marked by done;
// the receiver cannot stall them.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Reset: a clearing pass writes every accumulator and worker record; the
// queue still takes two beats, then busy stays high until the pass ends.
module gradient_aggregation_slot_engine_core import gase_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        src_ip,
    input  logic [14:0]        slot_number,
    input  logic [31:0]        tsi,
    input  logic [31:0]        worker_next,
    input  logic signed [15:0] worker_exp,
    input  logic signed [31:0] entry_value,
    input  logic               entry_last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               done,
    output logic [5:0]         out_slot,
    output logic [5:0]         out_index,
    output logic signed [31:0] out_value,
    output logic [31:0]        out_next,
    output logic signed [15:0] out_exp,
    output logic               out_last
);

    logic [4:0]  wc_reg;
    logic [6:0]  nu_reg;
    logic [14:0] base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg   <= 5'd1;
            nu_reg   <= 7'd64;
            base_reg <= 15'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WORKER_COUNT: wc_reg   <= cfg_data[4:0];
                REG_UPDATE_COUNT: nu_reg   <= cfg_data[6:0];
                REG_SLOT_BASE:    base_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    beat_t in_beat, q_beat;
    logic  q_full, q_valid, q_pop, bk_idle, push;

    assign in_beat = '{src_ip, slot_number, tsi, worker_next, worker_exp,
                       entry_value, entry_last};
    assign busy = q_full;
    assign push = start && !busy;

    gase_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_beat),
        .full(q_full), .pop(q_pop), .pop_data(q_beat), .not_empty(q_valid));

    gase_back #(
        .NUM_SLOTS(NUM_SLOTS), .MAX_ENTRIES(MAX_ENTRIES), .MAX_WORKERS(MAX_WORKERS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_beat), .q_pop(q_pop),
        .wc_cfg(wc_reg), .nu_cfg(nu_reg), .base_cfg(base_reg), .idle(bk_idle),
        .done(done), .out_slot(out_slot), .out_index(out_index),
        .out_value(out_value), .out_next(out_next), .out_exp(out_exp),
        .out_last(out_last));

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_done_busy_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !bk_idle || !$past(bk_idle)) else $error("result while idle");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push) else $error("push into full queue");

endmodule

// ===== rtl/gase_ram.sv =====
module gase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gase_queue.sv =====
module gase_queue import gase_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t push_data,
    output logic  full,
    input  logic  pop,
    output beat_t pop_data,
    output logic  not_empty
);

    beat_t      data_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = data_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/gase_back.sv =====
module gase_back import gase_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  beat_t              q_data,
    output logic               q_pop,
    input  logic [4:0]         wc_cfg,
    input  logic [6:0]         nu_cfg,
    input  logic [14:0]        base_cfg,
    output logic               idle,
    output logic               done,
    output logic [5:0]         out_slot,
    output logic [5:0]         out_index,
    output logic signed [31:0] out_value,
    output logic [31:0]        out_next,
    output logic signed [15:0] out_exp,
    output logic               out_last
);

    localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int AD   = NUM_SLOTS * MAX_ENTRIES;
    localparam int WD   = NUM_SLOTS * MAX_WORKERS;
    localparam int AW   = $clog2(AD + 1);
    localparam int WAW  = $clog2(WD + 1);
    localparam int AAW  = (AD > 1) ? $clog2(AD) : 1;
    localparam int WAAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int CW   = (AD > WD) ? AW : WAW;

    state_t state_reg, state_next;

    beat_t              it_reg;
    logic [5:0]         pos_reg;
    logic [SW-1:0]      loc_reg;
    logic               vld_reg;
    logic [CW-1:0]      ctr_reg;
    logic [6:0]         i_reg;
    logic [6:0]         kwc_reg;
    logic [31:0]        addr_reg [MAX_WORKERS];
    logic               found_reg;
    logic [31:0]        min_reg;
    logic               alleq_reg;
    logic signed [15:0] mexp_reg;
    logic [6:0]         wc_eff, nu_eff;

    assign wc_eff = ({2'b0, wc_cfg} > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : {2'b0, wc_cfg};
    assign nu_eff = (nu_cfg > 7'(MAX_ENTRIES)) ? 7'(MAX_ENTRIES) : nu_cfg;

    logic [15:0] diff;
    logic        q_inrange;
    assign diff      = {1'b0, q_data.slot_number} - {1'b0, base_cfg};
    assign q_inrange = !diff[15] && (diff[14:0] < 15'(NUM_SLOTS));

    logic            acc_we;
    logic [AAW-1:0]  acc_wa, acc_ra;
    logic [31:0]     acc_wd, acc_rd;
    logic            wn_we, we_we;
    logic [WAAW-1:0] w_wa, w_ra;
    logic [31:0]     wn_wd, wn_rd;
    logic [15:0]     we_wd, we_rd;

    gase_ram #(.WIDTH(32), .DEPTH(AD)) u_acc (
        .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
        .raddr(acc_ra), .rdata(acc_rd));
    gase_ram #(.WIDTH(32), .DEPTH(WD)) u_wnext (
        .clk(clk), .we(wn_we), .waddr(w_wa), .wdata(wn_wd),
        .raddr(w_ra), .rdata(wn_rd));
    gase_ram #(.WIDTH(16), .DEPTH(WD)) u_wexp (
        .clk(clk), .we(we_we), .waddr(w_wa), .wdata(we_wd),
        .raddr(w_ra), .rdata(we_rd));

    logic [AW+6:0]  acc_base;
    logic [WAW+6:0] w_base;
    assign acc_base = (AW+7)'(loc_reg) * (AW+7)'(MAX_ENTRIES);
    assign w_base   = (WAW+7)'(loc_reg) * (WAW+7)'(MAX_WORKERS);

    logic [EW-1:0] pos_e;
    logic [WW-1:0] i_w;
    logic [EW-1:0] i_e;
    assign pos_e = EW'(pos_reg);
    assign i_w   = WW'(i_reg);
    assign i_e   = EW'(i_reg);

    logic signed [15:0] rexp;
    assign rexp = we_rd;

    // running scan values including the record read this cycle
    logic        scan_alleq;
    logic [31:0] scan_min;

    always_comb
    begin
        scan_alleq = alleq_reg;
        scan_min   = min_reg;
        if (state_reg == ST_SCAN_CHK && i_reg != 7'd0)
        begin
            scan_alleq = alleq_reg && (wn_rd == it_reg.tsi);
            scan_min   = (wn_rd < min_reg) ? wn_rd : min_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (ctr_reg == CW'(((AD > WD) ? AD : WD) - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD:   state_next = ST_ACC_WR;
            ST_ACC_WR:
            begin
                if (!it_reg.entry_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN:
            begin
                if (i_reg >= kwc_reg || found_reg)
                begin
                    state_next = vld_reg ? ST_REC : ST_IDLE;
                end
            end
            ST_REC:      state_next = (wc_eff == 7'd0) ? ST_SCAN_CHK : ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (i_reg >= wc_eff)
                begin
                    if (scan_alleq || it_reg.tsi < scan_min)
                    begin
                        state_next = (wc_eff == 7'd0) ? ST_EMIT_RD : ST_EXP_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EXP_RD:   state_next = ST_EXP_CHK;
            ST_EXP_CHK:  state_next = (i_reg >= wc_eff) ? ST_EMIT_RD : ST_EXP_RD;
            ST_EMIT_RD:  state_next = (i_reg >= nu_eff) ? ST_IDLE : ST_EMIT_OUT;
            ST_EMIT_OUT: state_next = ST_EMIT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop  = (state_reg == ST_IDLE) && q_valid;
        idle   = (state_reg == ST_IDLE);
        acc_we = 1'b0;
        acc_wa = AAW'(acc_base + (AW+7)'(pos_e));
        acc_wd = acc_rd + it_reg.entry_value;
        acc_ra = AAW'(acc_base + (AW+7)'(pos_e));
        wn_we  = 1'b0;
        we_we  = 1'b0;
        w_wa   = WAAW'(w_base + (WAW+7)'(i_w));
        w_ra   = WAAW'(w_base + (WAW+7)'(i_w));
        wn_wd  = it_reg.worker_next;
        we_wd  = it_reg.worker_exp;
        unique case (state_reg)
            ST_CLEAR:
            begin
                acc_we = (ctr_reg < CW'(AD));
                acc_wa = AAW'(ctr_reg);
                acc_wd = 32'd0;
                wn_we  = (ctr_reg < CW'(WD));
                we_we  = wn_we;
                w_wa   = WAAW'(ctr_reg);
                wn_wd  = NEXT_INIT;
                we_wd  = EXP_FLOOR;
            end
            ST_ACC_WR:
            begin
                acc_we = vld_reg && ({1'b0, pos_reg} < nu_eff);
            end
            ST_REC:
            begin
                wn_we = found_reg && (i_reg < wc_eff);
                we_we = wn_we;
            end
            ST_EXP_CHK:
            begin
                w_wa  = WAAW'(w_base + (WAW+7)'(WW'(i_reg - 7'd1)));
                we_we = (wn_rd == min_reg) && (mexp_reg < rexp);
                we_wd = EXP_FLOOR;
            end
            ST_EMIT_RD:
            begin
                acc_ra = AAW'(acc_base + (AW+7)'(i_e));
            end
            ST_EMIT_OUT:
            begin
                acc_we = 1'b1;
                acc_wa = AAW'(acc_base + (AW+7)'(EW'(i_reg - 7'd1)));
                acc_wd = 32'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ctr_reg   <= '0;
            pos_reg   <= 6'd0;
            kwc_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                ctr_reg <= ctr_reg + CW'(1);
            end
            if (state_reg == ST_ACC_WR)
            begin
                pos_reg <= it_reg.entry_last ? 6'd0 : pos_reg + 6'd1;
            end
            if (state_reg == ST_LEARN && state_next != ST_LEARN && !found_reg
                && kwc_reg < wc_eff)
            begin
                kwc_reg <= kwc_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                it_reg    <= q_data;
                vld_reg   <= q_inrange;
                loc_reg   <= SW'(diff[14:0]);
                i_reg     <= 7'd0;
                found_reg <= 1'b0;
            end
            ST_LEARN:
            begin
                if (i_reg < kwc_reg && !found_reg)
                begin
                    if (addr_reg[i_w] == it_reg.src_ip)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                else if (!found_reg && kwc_reg < wc_eff)
                begin
                    addr_reg[WW'(kwc_reg)] <= it_reg.src_ip;
                    found_reg              <= 1'b1;
                end
            end
            ST_REC:
            begin
                i_reg     <= 7'd0;
                min_reg   <= NEXT_INIT;
                alleq_reg <= 1'b1;
                mexp_reg  <= EXP_FLOOR;
            end
            ST_SCAN_RD:
            begin
                i_reg <= i_reg + 7'd1;
            end
            ST_SCAN_CHK:
            begin
                alleq_reg <= scan_alleq;
                min_reg   <= scan_min;
                if (state_next != ST_SCAN_RD)
                begin
                    i_reg <= 7'd0;
                end
            end
            ST_EXP_RD:
            begin
                i_reg <= i_reg + 7'd1;
            end
            ST_EXP_CHK:
            begin
                if (wn_rd == min_reg && mexp_reg < rexp)
                begin
                    mexp_reg <= rexp;
                end
                if (i_reg >= wc_eff)
                begin
                    i_reg <= 7'd0;
                end
            end
            ST_EMIT_RD:
            begin
                i_reg <= i_reg + 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done      = (state_reg == ST_EMIT_OUT);
    assign out_slot  = 6'(loc_reg);
    assign out_index = 6'(i_reg - 7'd1);
    assign out_value = acc_rd;
    assign out_next  = min_reg;
    assign out_exp   = mexp_reg;
    assign out_last  = (i_reg == nu_eff);

endmodule
